[rtl/unix_to_local_civil_date_dst_defines.svh]
// Assertion macros shared by the converter RTL.
`ifndef UNIX_TO_LOCAL_CIVIL_DATE_DST_DEFINES_SVH
`define UNIX_TO_LOCAL_CIVIL_DATE_DST_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define ULCD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ulcd same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define ULCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ulcd next-cycle check failed");

`endif

[rtl/ulcd_pkg.sv]
// Shared widths, constants, reciprocals and tables for the civil date converter.
`default_nettype none

package ulcd_pkg;

  localparam int SecondsWidth  = 32;
  localparam int OffsetWidth   = 11;
  localparam int YearWidth     = 12;
  localparam int MonthWidth    = 4;
  localparam int DayWidth      = 5;
  localparam int SodWidth      = 17;
  localparam int KeyWidth      = 20;
  localparam int DaysWidth     = 16;
  localparam int SideWidth     = 32;
  localparam int CfgIndexWidth = 2;

  localparam logic [CfgIndexWidth-1:0] RegStandardOffset = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegSummerOffset   = 2'd1;

  localparam logic signed [OffsetWidth-1:0] StandardOffsetReset = 11'sd60;
  localparam logic signed [OffsetWidth-1:0] SummerOffsetReset   = 11'sd120;

  localparam logic [MonthWidth-1:0] MonthMarch     = 4'd3;
  localparam logic [MonthWidth-1:0] MonthApril     = 4'd4;
  localparam logic [MonthWidth-1:0] MonthSeptember = 4'd9;
  localparam logic [MonthWidth-1:0] MonthOctober   = 4'd10;

  localparam logic [SecondsWidth-1:0] SecondsPerDay = 32'd86400;
  localparam logic [SodWidth-1:0]     SecondsPerHour = 17'd3600;

  // 86400 = 2^7 * 675: shift out the power of two, then scale by 1/675.
  localparam int DayShift      = 7;
  localparam int Recip675Shift = 35;
  localparam logic [25:0] Recip675 =
    26'(((64'd1 << Recip675Shift) + 64'd675 - 64'd1) / 64'd675);

  localparam logic [19:0] EpochShift = 20'd719468;
  localparam logic [19:0] Era4Start  = 20'd584388;
  localparam logic [19:0] Era5Start  = 20'd730485;
  localparam logic [YearWidth-1:0] Era4Year = 12'd1600;
  localparam logic [YearWidth-1:0] Era5Year = 12'd2000;

  localparam logic [17:0] CenturyDays1 = 18'd36524;
  localparam logic [17:0] CenturyDays2 = 18'd73048;
  localparam logic [17:0] CenturyDays3 = 18'd109572;
  localparam logic [17:0] CenturyDays4 = 18'd146096;

  localparam int Recip1460Shift = 29;
  localparam logic [18:0] Recip1460 =
    19'(((64'd1 << Recip1460Shift) + 64'd1460 - 64'd1) / 64'd1460);
  localparam int Recip365Shift = 27;
  localparam logic [18:0] Recip365 =
    19'(((64'd1 << Recip365Shift) + 64'd365 - 64'd1) / 64'd365);
  localparam int Recip153Shift = 19;
  localparam logic [11:0] Recip153 =
    12'(((64'd1 << Recip153Shift) + 64'd153 - 64'd1) / 64'd153);
  localparam int Recip100Shift = 19;
  localparam logic [12:0] Recip100 =
    13'(((64'd1 << Recip100Shift) + 64'd100 - 64'd1) / 64'd100);
  localparam int Recip400Shift = 21;
  localparam logic [12:0] Recip400 =
    13'(((64'd1 << Recip400Shift) + 64'd400 - 64'd1) / 64'd400);
  localparam int Recip7Shift = 16;
  localparam logic [13:0] Recip7 =
    14'(((64'd1 << Recip7Shift) + 64'd7 - 64'd1) / 64'd7);

  // Month bias plus the 31 of the last day: March has bias 2, October bias 6.
  localparam logic [12:0] WeekdayBiasMarch   = 13'd33;
  localparam logic [12:0] WeekdayBiasOctober = 13'd37;

  localparam logic [KeyWidth-1:0] KeyYearWeight  = 20'd372;
  localparam logic [KeyWidth-1:0] KeyMonthWeight = 20'd31;

  typedef struct packed {
    logic [YearWidth-1:0]  year;
    logic [MonthWidth-1:0] month;
    logic [DayWidth-1:0]   day;
  } civil_t;

  // First day-of-year of each month in a March-based year.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/ulcd_date.sv]
// Eight-stage pipeline: second count to civil date and second of day.
`default_nettype none

module ulcd_date (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire [ulcd_pkg::SecondsWidth-1:0]   seconds,
  input  wire [ulcd_pkg::SideWidth-1:0]      side_in,
  output logic                               out_valid,
  input  wire                                out_ready,
  output ulcd_pkg::civil_t                   date,
  output logic [ulcd_pkg::SodWidth-1:0]      sod,
  output logic [ulcd_pkg::SideWidth-1:0]     side_out
);

  localparam int NumStages = 8;

  logic [NumStages-1:0] vld;
  logic [NumStages-1:0] vld_next;
  logic [NumStages-1:0] en;

  assign en[NumStages-1] = !vld[NumStages-1] || out_ready;
  for (genvar k = 0; k < NumStages - 1; k++) begin : g_ready
    assign en[k] = !vld[k] || en[k+1];
  end

  assign vld_next = (en & {vld[NumStages-2:0], in_valid}) | (~en & vld);
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  // sideband and second-of-day travel alongside the date math
  logic [ulcd_pkg::SideWidth-1:0] side_q [NumStages];
  logic [ulcd_pkg::SodWidth-1:0]  sod_q  [1:NumStages-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_q[0] <= side_in;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // stage 0: scale by reciprocal of the odd part of 86400
  logic [ulcd_pkg::SecondsWidth-1:0] sec0;
  logic [50:0]                       prod0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sec0  <= seconds;
      prod0 <= 51'(seconds[ulcd_pkg::SecondsWidth-1:ulcd_pkg::DayShift])
               * 51'(ulcd_pkg::Recip675);
    end
  end

  // stage 1: day number and remainder
  logic [ulcd_pkg::DaysWidth-1:0] days_c;
  logic [ulcd_pkg::DaysWidth-1:0] days1;

  assign days_c = prod0[ulcd_pkg::Recip675Shift +: ulcd_pkg::DaysWidth];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      days1    <= days_c;
      sod_q[1] <= ulcd_pkg::SodWidth'(sec0
                  - ulcd_pkg::SecondsWidth'(days_c) * ulcd_pkg::SecondsPerDay);
    end
    for (int k = 2; k < NumStages; k++) begin
      if (en[k]) begin
        sod_q[k] <= sod_q[k-1];
      end
    end
  end

  // stage 2: shift to March-based eras, pick the era
  logic [19:0] z_c;
  logic        era_hi_c;
  logic [17:0] doe2;
  logic        era2;

  assign z_c      = 20'(days1) + ulcd_pkg::EpochShift;
  assign era_hi_c = z_c >= ulcd_pkg::Era5Start;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      doe2 <= 18'(z_c - (era_hi_c ? ulcd_pkg::Era5Start : ulcd_pkg::Era4Start));
      era2 <= era_hi_c;
    end
  end

  // stage 3: leap-cycle corrections
  logic [36:0] prod3;
  logic [2:0]  cent3;
  logic        last3;
  logic [17:0] doe3;
  logic        era3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      prod3 <= 37'(doe2) * 37'(ulcd_pkg::Recip1460);
      cent3 <= 3'(doe2 >= ulcd_pkg::CenturyDays1) + 3'(doe2 >= ulcd_pkg::CenturyDays2)
             + 3'(doe2 >= ulcd_pkg::CenturyDays3) + 3'(doe2 >= ulcd_pkg::CenturyDays4);
      last3 <= doe2 >= ulcd_pkg::CenturyDays4;
      doe3  <= doe2;
      era3  <= era2;
    end
  end

  // stage 4: year of era by scaling with 1/365
  logic [17:0] n_c;
  logic [36:0] prod4;
  logic [17:0] doe4;
  logic        era4;

  assign n_c = doe3 - 18'(prod3[36:ulcd_pkg::Recip1460Shift]) + 18'(cent3) - 18'(last3);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      prod4 <= 37'(n_c) * 37'(ulcd_pkg::Recip365);
      doe4  <= doe3;
      era4  <= era3;
    end
  end

  // stage 5: day of year
  logic [8:0]  yoe_c;
  logic [1:0]  cent_y_c;
  logic [17:0] year_days_c;
  logic [8:0]  doy5;
  logic [8:0]  yoe5;
  logic        era5;

  assign yoe_c       = prod4[ulcd_pkg::Recip365Shift +: 9];
  assign cent_y_c    = 2'(yoe_c >= 9'd100) + 2'(yoe_c >= 9'd200) + 2'(yoe_c >= 9'd300);
  assign year_days_c = 18'(yoe_c) * 18'd365 + 18'(yoe_c[8:2]) - 18'(cent_y_c);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      doy5 <= 9'(doe4 - year_days_c);
      yoe5 <= yoe_c;
      era5 <= era4;
    end
  end

  // stage 6: March-based month index
  logic [10:0] mx_c;
  logic [22:0] prod6_c;
  logic [3:0]  mp6;
  logic [8:0]  doy6;
  logic [8:0]  yoe6;
  logic        era6;

  assign mx_c    = 11'({doy5, 2'b00}) + 11'(doy5) + 11'd2;
  assign prod6_c = 23'(mx_c) * 23'(ulcd_pkg::Recip153);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      mp6  <= prod6_c[ulcd_pkg::Recip153Shift +: 4];
      doy6 <= doy5;
      yoe6 <= yoe5;
      era6 <= era5;
    end
  end

  // stage 7: calendar month, day and year
  logic [ulcd_pkg::MonthWidth-1:0] mon_c;
  ulcd_pkg::civil_t                date7;

  assign mon_c = (mp6 < 4'd10) ? mp6 + 4'd3 : mp6 - 4'd9;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      date7.day   <= 5'(doy6 - ulcd_pkg::month_start(mp6) + 9'd1);
      date7.month <= mon_c;
      date7.year  <= 12'(yoe6) + (era6 ? ulcd_pkg::Era5Year : ulcd_pkg::Era4Year)
                     + 12'(mon_c <= 4'd2);
    end
  end

  assign out_valid = vld[NumStages-1];
  assign date      = date7;
  assign sod       = sod_q[NumStages-1];
  assign side_out  = side_q[NumStages-1];

endmodule

`default_nettype wire

[rtl/unix_to_local_civil_date_dst.sv]
// Unix UTC seconds to local civil date with EU summer time, fully pipelined.
// Throughput: one beat per cycle unless result_ready stalls the output; depth
// is two 8-stage date converters plus four offset stages and the date-key
// output register.
// Reset: synchronous rst empties every stage and loads offsets 60 and 120 min.
`default_nettype none
`include "unix_to_local_civil_date_dst_defines.svh"

module unix_to_local_civil_date_dst (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     item_valid,
  output logic                                    item_ready,
  input  wire [ulcd_pkg::SecondsWidth-1:0]        utc_seconds,
  output logic                                    result_valid,
  input  wire                                     result_ready,
  output logic [ulcd_pkg::YearWidth-1:0]          local_year,
  output logic [ulcd_pkg::MonthWidth-1:0]         local_month,
  output logic [ulcd_pkg::DayWidth-1:0]           local_day,
  output logic [ulcd_pkg::SodWidth-1:0]           second_of_day,
  output logic signed [ulcd_pkg::OffsetWidth-1:0] zone_offset_min,
  output logic [ulcd_pkg::KeyWidth-1:0]           date_key,
  input  wire                                     cfg_valid,
  output logic                                    cfg_ready,
  input  wire [ulcd_pkg::CfgIndexWidth-1:0]       cfg_index,
  input  wire [ulcd_pkg::OffsetWidth-1:0]         cfg_data
);

  localparam int NumDst = 4;

  // configuration registers
  logic signed [ulcd_pkg::OffsetWidth-1:0] std_off;
  logic signed [ulcd_pkg::OffsetWidth-1:0] sum_off;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      std_off <= ulcd_pkg::StandardOffsetReset;
      sum_off <= ulcd_pkg::SummerOffsetReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ulcd_pkg::RegStandardOffset: std_off <= cfg_data;
        ulcd_pkg::RegSummerOffset:   sum_off <= cfg_data;
        default: ;
      endcase
    end
  end

  // UTC date
  logic                              utc_vld;
  ulcd_pkg::civil_t                  utc_date;
  logic [ulcd_pkg::SodWidth-1:0]     utc_sod;
  logic [ulcd_pkg::SideWidth-1:0]    utc_side;
  logic [NumDst-1:0]                 dv;
  logic [NumDst-1:0]                 dv_next;
  logic [NumDst-1:0]                 dv_en;
  logic                              loc_ready;

  ulcd_date u_utc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_ready  (item_ready),
    .seconds   (utc_seconds),
    .side_in   (utc_seconds),
    .out_valid (utc_vld),
    .out_ready (dv_en[0]),
    .date      (utc_date),
    .sod       (utc_sod),
    .side_out  (utc_side)
  );

  // offset stages
  assign dv_en[NumDst-1] = !dv[NumDst-1] || loc_ready;
  for (genvar k = 0; k < NumDst - 1; k++) begin : g_dst_ready
    assign dv_en[k] = !dv[k] || dv_en[k+1];
  end

  assign dv_next = (dv_en & {dv[NumDst-2:0], utc_vld}) | (~dv_en & dv);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
    end else begin
      dv <= dv_next;
    end
  end

  // stage 0: century and 400-year counts of the UTC year
  logic [24:0]                       prod100_0;
  logic [24:0]                       prod400_0;
  logic [ulcd_pkg::YearWidth-1:0]    year0;
  logic [ulcd_pkg::MonthWidth-1:0]   month0;
  logic [ulcd_pkg::DayWidth-1:0]     day0;
  logic                              late0;
  logic [ulcd_pkg::SecondsWidth-1:0] utc0;

  always_ff @(posedge clk) begin
    if (dv_en[0]) begin
      prod100_0 <= 25'(utc_date.year) * 25'(ulcd_pkg::Recip100);
      prod400_0 <= 25'(utc_date.year) * 25'(ulcd_pkg::Recip400);
      year0     <= utc_date.year;
      month0    <= utc_date.month;
      day0      <= utc_date.day;
      late0     <= utc_sod >= ulcd_pkg::SecondsPerHour;
      utc0      <= utc_side;
    end
  end

  // stage 1: weekday sum of the 31st, scaled by 1/7
  logic [12:0]                       wsum_c;
  logic [12:0]                       wsum1;
  logic [26:0]                       prod7_1;
  logic [ulcd_pkg::MonthWidth-1:0]   month1;
  logic [ulcd_pkg::DayWidth-1:0]     day1;
  logic                              late1;
  logic [ulcd_pkg::SecondsWidth-1:0] utc1;

  assign wsum_c = 13'(year0) + 13'(year0[ulcd_pkg::YearWidth-1:2])
                - 13'(prod100_0[24:ulcd_pkg::Recip100Shift])
                + 13'(prod400_0[24:ulcd_pkg::Recip400Shift])
                + ((month0 == ulcd_pkg::MonthOctober) ? ulcd_pkg::WeekdayBiasOctober
                                                      : ulcd_pkg::WeekdayBiasMarch);

  always_ff @(posedge clk) begin
    if (dv_en[1]) begin
      wsum1   <= wsum_c;
      prod7_1 <= 27'(wsum_c) * 27'(ulcd_pkg::Recip7);
      month1  <= month0;
      day1    <= day0;
      late1   <= late0;
      utc1    <= utc0;
    end
  end

  // stage 2: last Sunday and summer-time decision
  logic [10:0]                             q7_c;
  logic [2:0]                              wday_c;
  logic [ulcd_pkg::DayWidth-1:0]           last_sun_c;
  logic                                    past_switch_c;
  logic                                    summer_c;
  logic signed [ulcd_pkg::OffsetWidth-1:0] off2;
  logic [ulcd_pkg::SecondsWidth-1:0]       utc2;

  always_comb begin
    q7_c          = prod7_1[26:ulcd_pkg::Recip7Shift];
    wday_c        = 3'(wsum1 - 13'(q7_c) * 13'd7);
    last_sun_c    = 5'd31 - 5'(wday_c);
    past_switch_c = (day1 == last_sun_c) ? late1 : (day1 > last_sun_c);
    if (month1 inside {[ulcd_pkg::MonthApril:ulcd_pkg::MonthSeptember]}) begin
      summer_c = 1'b1;
    end else if (month1 == ulcd_pkg::MonthMarch) begin
      summer_c = past_switch_c;
    end else if (month1 == ulcd_pkg::MonthOctober) begin
      summer_c = !past_switch_c;
    end else begin
      summer_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_en[2]) begin
      off2 <= summer_c ? sum_off : std_off;
      utc2 <= utc1;
    end
  end

  // stage 3: local second count, wraps modulo 2^32
  logic signed [ulcd_pkg::SecondsWidth-1:0] off_wide_c;
  logic signed [ulcd_pkg::SecondsWidth-1:0] off_sec_c;
  logic [ulcd_pkg::SecondsWidth-1:0]        local3;
  logic signed [ulcd_pkg::OffsetWidth-1:0]  off3;
  logic [ulcd_pkg::SideWidth-1:0]           loc_side_in;

  assign off_wide_c = 32'(off2);
  assign off_sec_c  = off_wide_c * 32'sd60;

  always_ff @(posedge clk) begin
    if (dv_en[3]) begin
      local3 <= utc2 + unsigned'(off_sec_c);
      off3   <= off2;
    end
  end

  assign loc_side_in = {{(ulcd_pkg::SideWidth - ulcd_pkg::OffsetWidth){1'b0}}, off3};

  // local date
  logic                           loc_vld;
  ulcd_pkg::civil_t               loc_date;
  logic [ulcd_pkg::SodWidth-1:0]  loc_sod;
  logic [ulcd_pkg::SideWidth-1:0] loc_side;
  logic                           k_en;

  ulcd_date u_local (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv[NumDst-1]),
    .in_ready  (loc_ready),
    .seconds   (local3),
    .side_in   (loc_side_in),
    .out_valid (loc_vld),
    .out_ready (k_en),
    .date      (loc_date),
    .sod       (loc_sod),
    .side_out  (loc_side)
  );

  // output register with date key
  assign k_en = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (k_en) begin
      result_valid <= loc_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (k_en) begin
      local_year      <= loc_date.year;
      local_month     <= loc_date.month;
      local_day       <= loc_date.day;
      second_of_day   <= loc_sod;
      zone_offset_min <= loc_side[ulcd_pkg::OffsetWidth-1:0];
      date_key        <= 20'(loc_date.year) * ulcd_pkg::KeyYearWeight
                       + 20'(loc_date.month) * ulcd_pkg::KeyMonthWeight
                       + 20'(loc_date.day);
    end
  end

  `ULCD_ASSERT_IMPL(a_month_range, clk, rst, result_valid, local_month >= 4'd1 && local_month <= 4'd12)
  `ULCD_ASSERT_IMPL(a_day_nonzero, clk, rst, result_valid, local_day != 5'd0)
  `ULCD_ASSERT_IMPL(a_sod_range, clk, rst, result_valid, second_of_day < 17'd86400)
  `ULCD_ASSERT_IMPL(a_empty_out_ready, clk, rst, !result_valid, item_ready)
  `ULCD_ASSERT_NEXT(a_dst_hold, clk, rst, dv[NumDst-1] && !loc_ready, dv[NumDst-1])

endmodule

`default_nettype wire
